>>> src/bdq_pkg.sv
package bdq_pkg;

	// Ring capacity in entries.
	localparam int unsigned DEPTH = 16;
	localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned OCC_W = $clog2(DEPTH + 1);

	localparam int unsigned CMD_W  = 3;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned STAT_W = 2;

	// Stream payload widths, padded to whole bytes.
	localparam int unsigned IN_BITS   = CMD_W + DATA_W;
	localparam int unsigned OUT_BITS  = DATA_W + 1 + 1 + STAT_W;
	localparam int unsigned IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [OCC_W-1:0] occ_t;

	typedef struct packed {
		logic [STAT_W-1:0]        status;
		logic                     now_empty;
		logic                     found;
		logic signed [DATA_W-1:0] popped_value;
	} result_t;

endpackage

>>> src/bounded_deque_with_search.sv
// Bounded double-ended queue of signed 32-bit values with a search command.
// Input stream (s_*): one transfer is one command, with the command code and
// the value to push or to search for. Output stream (m_*): exactly one result
// transfer per command, carrying the popped value, the found flag, the
// empty flag after the command, and a status (ok, pop on empty, push on full).
// The entries live in a single-port synchronous RAM of DEPTH words with a
// registered read port; head index and occupancy live in flip-flops.
// Pushes, failed pops, unknown codes and searches on an empty queue register
// their result directly; pops pass through the RAM read and S_POP; a search
// passes through S_SCAN, where the RAM port reads one stored entry per cycle.
// Commands are handled one at a time; a new command is taken once the current
// one has placed its result in the output register and that register is free
// or being emptied in the same cycle. Reset empties the queue (head and
// occupancy cleared); RAM contents are not cleared and need no clearing pass.
// If the receiver stalls, the result holds in the output register and no
// further command is accepted until it leaves.
module bounded_deque_with_search (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// command [2:0], item_value [34:3], zero padding above
	input  logic [bdq_pkg::IN_TDATA_W-1:0]    s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// popped_value [31:0], found [32], now_empty [33], status [35:34], zero padding above
	output logic [bdq_pkg::OUT_TDATA_W-1:0]   m_tdata
);
	import bdq_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP,
		S_SCAN
	} state_t;

	state_t                   state_q;
	idx_t                     head_q;
	occ_t                     occ_q;
	idx_t                     ptr_q;
	occ_t                     cnt_q;
	logic                     found_q;
	logic signed [DATA_W-1:0] val_q;
	logic                     out_valid_q;
	result_t                  out_q;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	logic                     accept;
	logic [CMD_W-1:0]         in_cmd;
	logic signed [DATA_W-1:0] in_val;
	logic                     is_full;
	logic                     is_empty;
	logic                     rd_en;
	idx_t                     rd_addr;
	logic                     wr_en;
	idx_t                     wr_addr;
	idx_t                     head_dec;
	logic                     hit;

	// Ring index arithmetic: base + offset, folded once into 0..DEPTH-1.
	function automatic idx_t wrap_add(input idx_t base, input idx_t offset);
		logic [IDX_W:0] sum;
		begin
			sum = {1'b0, base} + {1'b0, offset};
			if (sum >= (IDX_W+1)'(DEPTH))
				sum = sum - (IDX_W+1)'(DEPTH);
			return sum[IDX_W-1:0];
		end
	endfunction

	assign in_cmd   = s_tdata[CMD_W-1:0];
	assign in_val   = s_tdata[CMD_W+DATA_W-1:CMD_W];
	assign s_tready = (state_q == S_IDLE) && (!out_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign is_full  = (occ_q == OCC_W'(DEPTH));
	assign is_empty = (occ_q == '0);
	assign head_dec = (head_q == '0) ? IDX_W'(DEPTH - 1) : head_q - idx_t'(1);
	assign hit      = (rd_data_q == val_q);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = head_dec;
		rd_en   = 1'b0;
		rd_addr = head_q;
		if (accept) begin
			case (in_cmd)
				CMD_PUSH_FRONT: begin
					wr_en   = !is_full;
					wr_addr = head_dec;
				end
				CMD_PUSH_BACK: begin
					wr_en   = !is_full;
					wr_addr = wrap_add(head_q, occ_q[IDX_W-1:0]);
				end
				CMD_POP_FRONT: begin
					rd_en   = !is_empty;
					rd_addr = head_q;
				end
				CMD_POP_BACK: begin
					rd_en   = !is_empty;
					rd_addr = wrap_add(head_q, IDX_W'(occ_q - occ_t'(1)));
				end
				CMD_SEARCH: begin
					rd_en   = !is_empty;
					rd_addr = head_q;
				end
				default: begin
					rd_en = 1'b0;
				end
			endcase
		end else if (state_q == S_SCAN && cnt_q != occ_t'(1)) begin
			rd_en   = 1'b1;
			rd_addr = ptr_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= in_val;
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			occ_q       <= '0;
			ptr_q       <= '0;
			cnt_q       <= '0;
			found_q     <= 1'b0;
			val_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						val_q                <= in_val;
						out_q.popped_value   <= '0;
						out_q.found          <= 1'b0;
						out_q.status         <= ST_OK;
						out_q.now_empty      <= is_empty;
						case (in_cmd)
							CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
								out_valid_q <= 1'b1;
								if (is_full) begin
									out_q.status <= ST_FULL;
								end else begin
									occ_q           <= occ_q + occ_t'(1);
									out_q.now_empty <= 1'b0;
									if (in_cmd == CMD_PUSH_FRONT)
										head_q <= head_dec;
								end
							end
							CMD_POP_FRONT, CMD_POP_BACK: begin
								if (is_empty) begin
									out_q.status <= ST_EMPTY;
									out_valid_q  <= 1'b1;
								end else begin
									occ_q   <= occ_q - occ_t'(1);
									state_q <= S_POP;
									if (in_cmd == CMD_POP_FRONT)
										head_q <= wrap_add(head_q, idx_t'(1));
								end
							end
							CMD_SEARCH: begin
								if (is_empty) begin
									out_valid_q <= 1'b1;
								end else begin
									ptr_q   <= wrap_add(head_q, idx_t'(1));
									cnt_q   <= occ_q;
									found_q <= 1'b0;
									state_q <= S_SCAN;
								end
							end
							default: begin
								out_valid_q <= 1'b1;
							end
						endcase
					end
				end
				S_POP: begin
					// The output register was free, or being emptied, when the pop was accepted.
					out_q.popped_value <= rd_data_q;
					out_q.now_empty    <= is_empty;
					out_valid_q        <= 1'b1;
					state_q            <= S_IDLE;
				end
				S_SCAN: begin
					// Each cycle compares the entry read in the previous cycle.
					if (cnt_q == occ_t'(1)) begin
						out_q.found <= found_q || hit;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						found_q <= found_q || hit;
						ptr_q   <= wrap_add(ptr_q, idx_t'(1));
						cnt_q   <= cnt_q - occ_t'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W - OUT_BITS){1'b0}}, out_q};

endmodule

>>> bench/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bdq_pkg::*;

	localparam int unsigned CLK_HALF     = 6;
	localparam int unsigned RESET_CYCLES = 6;
	localparam int unsigned RANDOM_ITEMS = 1110;
	localparam int unsigned IDLE_LIMIT   = 4000;

	// Command codes the block treats as no operation.
	localparam logic [CMD_W-1:0] CMD_NOP_FIRST = 3'd5;
	localparam logic [CMD_W-1:0] CMD_NOP_LAST  = 3'd7;

	localparam logic [DATA_W-1:0] VAL_MIN  = 32'h8000_0000;
	localparam logic [DATA_W-1:0] VAL_MAX  = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] VAL_ZERO = 32'h0000_0000;
	localparam logic [DATA_W-1:0] VAL_NEG1 = 32'hFFFF_FFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	// Shadow copy of the deque contents.
	logic [DATA_W-1:0] ring_mem [DEPTH];
	idx_t ring_head;
	occ_t ring_count;

	result_t awaited_results[$];
	int unsigned error_count = 0;
	int unsigned commands_sent = 0;
	int unsigned idle_cycles = 0;
	int unsigned stall_left = 0;
	bit gaps_on = 1'b1;
	bit stall_on = 1'b1;

	bounded_deque_with_search u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever begin
			#(CLK_HALF) clk = ~clk;
		end
	end

	function automatic idx_t slot_of(int unsigned offset);
		return idx_t'((int'(ring_head) + offset) % DEPTH);
	endfunction

	// Applies one command to the shadow deque and returns the result it must produce.
	function automatic result_t predict_deque_result(logic [CMD_W-1:0] cmd,
			logic [DATA_W-1:0] val);
		result_t r;
		int unsigned i;
		r = '0;
		r.status = ST_OK;
		case (cmd)
			CMD_PUSH_FRONT: begin
				if (ring_count >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					ring_head = slot_of(DEPTH - 1);
					ring_mem[ring_head] = val;
					ring_count = ring_count + 1'b1;
				end
			end
			CMD_PUSH_BACK: begin
				if (ring_count >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					ring_mem[slot_of(ring_count)] = val;
					ring_count = ring_count + 1'b1;
				end
			end
			CMD_POP_FRONT: begin
				if (ring_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.popped_value = ring_mem[ring_head];
					ring_head = slot_of(1);
					ring_count = ring_count - 1'b1;
				end
			end
			CMD_POP_BACK: begin
				if (ring_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.popped_value = ring_mem[slot_of(ring_count - 1)];
					ring_count = ring_count - 1'b1;
				end
			end
			CMD_SEARCH: begin
				for (i = 0; i < ring_count; i++) begin
					if (ring_mem[slot_of(i)] == val) begin
						r.found = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		r.now_empty = (ring_count == 0);
		return r;
	endfunction

	// Mostly back-to-back transfers, some short gaps and a few long ones.
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (!gaps_on) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 93) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [DATA_W-1:0] random_value();
		case ($urandom_range(0, 19))
			0: return VAL_MIN;
			1: return VAL_MAX;
			2: return VAL_ZERO;
			3: return VAL_NEG1;
			default: return $urandom();
		endcase
	endfunction

	task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] val);
		int unsigned gap;
		logic accepted;
		gap = pick_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= IN_TDATA_W'({val, cmd});
		// The handshake is sampled mid-cycle, where both sides are settled.
		accepted = 1'b0;
		while (!accepted) begin
			@(negedge clk);
			accepted = s_tready;
			@(posedge clk);
		end
		awaited_results.push_back(predict_deque_result(cmd, val));
		if (cmd <= CMD_SEARCH) begin
			commands_sent++;
		end
	endtask

	task automatic send_random_push();
		send_command($urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, random_value());
	endtask

	task automatic send_random_pop();
		send_command($urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT, $urandom());
	endtask

	// Searches hit a stored value, a value one bit away from one, or a random value.
	task automatic send_search();
		logic [DATA_W-1:0] val;
		int unsigned r;
		r = $urandom_range(0, 9);
		val = random_value();
		if (ring_count != 0 && r < 7) begin
			val = ring_mem[slot_of($urandom_range(0, ring_count - 1))];
			if (r >= 5) begin
				val[$urandom_range(0, DATA_W - 1)] ^= 1'b1;
			end
		end
		send_command(CMD_SEARCH, val);
	endtask

	task automatic test_empty_queue();
		logic [CMD_W-1:0] cmd;
		send_command(CMD_POP_FRONT, VAL_NEG1);
		send_command(CMD_POP_BACK, VAL_MIN);
		send_command(CMD_SEARCH, VAL_ZERO);
		for (cmd = CMD_NOP_FIRST; cmd != CMD_NOP_LAST; cmd++) begin
			send_command(cmd, VAL_NEG1);
		end
		send_command(CMD_NOP_LAST, VAL_MAX);
	endtask

	task automatic test_extreme_values();
		send_command(CMD_PUSH_FRONT, VAL_MIN);
		send_command(CMD_PUSH_BACK, VAL_MAX);
		send_command(CMD_PUSH_FRONT, VAL_NEG1);
		send_command(CMD_PUSH_BACK, VAL_ZERO);
		send_command(CMD_SEARCH, VAL_MIN);
		send_command(CMD_SEARCH, VAL_MAX);
		send_command(CMD_SEARCH, 32'h0000_0001);
		send_command(CMD_NOP_FIRST, VAL_ZERO);
		send_command(CMD_POP_FRONT, VAL_ZERO);
		send_command(CMD_POP_BACK, VAL_ZERO);
		send_command(CMD_POP_FRONT, VAL_NEG1);
		send_command(CMD_POP_BACK, VAL_NEG1);
		send_command(CMD_POP_BACK, VAL_ZERO);
	endtask

	// Fill to capacity, push past it, then drain across the wrap point.
	task automatic test_full_queue();
		while (ring_count < DEPTH) begin
			send_random_push();
		end
		send_command(CMD_PUSH_FRONT, VAL_MAX);
		send_command(CMD_PUSH_BACK, VAL_MIN);
		send_search();
		send_command(CMD_NOP_LAST, VAL_ZERO);
		send_command(CMD_POP_FRONT, VAL_ZERO);
		send_command(CMD_PUSH_BACK, VAL_NEG1);
		send_command(CMD_POP_BACK, VAL_ZERO);
		while (ring_count != 0) begin
			send_random_pop();
		end
		send_command(CMD_POP_FRONT, VAL_ZERO);
	endtask

	task automatic test_random_traffic();
		int unsigned target;
		int unsigned kind;
		int unsigned n;
		int unsigned k;
		int unsigned r;
		target = commands_sent + RANDOM_ITEMS;
		while (commands_sent < target) begin
			gaps_on = ($urandom_range(0, 7) != 0);
			stall_on = ($urandom_range(0, 7) != 0);
			kind = $urandom_range(0, 9);
			if (kind < 5) begin
				n = $urandom_range(5, 30);
				for (k = 0; k < n; k++) begin
					r = $urandom_range(0, 99);
					if (r < 40) begin
						send_random_push();
					end else if (r < 72) begin
						send_random_pop();
					end else begin
						send_search();
					end
				end
			end else if (kind < 7) begin
				while (ring_count < DEPTH) begin
					if ($urandom_range(0, 4) == 0) begin
						send_search();
					end else begin
						send_random_push();
					end
				end
				n = $urandom_range(1, 3);
				for (k = 0; k < n; k++) begin
					send_random_push();
					send_search();
				end
			end else if (kind < 9) begin
				while (ring_count != 0) begin
					if ($urandom_range(0, 4) == 0) begin
						send_search();
					end else begin
						send_random_pop();
					end
				end
				n = $urandom_range(1, 2);
				for (k = 0; k < n; k++) begin
					send_random_pop();
				end
				send_search();
			end else begin
				n = $urandom_range(1, 6);
				for (k = 0; k < n; k++) begin
					send_command(CMD_W'($urandom_range(CMD_PUSH_FRONT, CMD_NOP_LAST)),
						$urandom());
				end
			end
		end
		gaps_on = 1'b1;
		stall_on = 1'b1;
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		ring_head = '0;
		ring_count = '0;
		repeat (2) @(posedge clk);
		test_empty_queue();
		test_extreme_values();
		test_full_queue();
		test_random_traffic();
		s_tvalid <= 1'b0;
		while (awaited_results.size() != 0) begin
			@(posedge clk);
		end
		// Any stray result would show up within a full search time.
		repeat (2 * DEPTH + 4) @(posedge clk);
		if (error_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Checks every result transfer and drives the receiver's stalls.
	initial begin
		logic fire;
		logic [OUT_TDATA_W-1:0] word;
		result_t got;
		result_t want;
		int unsigned r;
		forever begin
			@(negedge clk);
			fire = arst_n && m_tvalid && m_tready;
			word = m_tdata;
			@(posedge clk);
			if (fire) begin
				got = result_t'(word[OUT_BITS-1:0]);
				if (awaited_results.size() == 0) begin
					$error("result transfer with no command outstanding: %h", word);
					error_count++;
				end else begin
					want = awaited_results.pop_front();
					if (got.popped_value !== want.popped_value) begin
						$error("popped_value: expected %0d, got %0d",
							want.popped_value, got.popped_value);
						error_count++;
					end
					if (got.found !== want.found) begin
						$error("found: expected %0b, got %0b", want.found, got.found);
						error_count++;
					end
					if (got.now_empty !== want.now_empty) begin
						$error("now_empty: expected %0b, got %0b",
							want.now_empty, got.now_empty);
						error_count++;
					end
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						error_count++;
					end
				end
			end
			if (!stall_on) begin
				m_tready <= 1'b1;
			end else if (stall_left != 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					m_tready <= 1'b1;
				end else begin
					stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
					m_tready <= 1'b0;
				end
			end
		end
	end

	// Ends the run if no transfer happens on either side for too long.
	always @(negedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

>>> files.f
src/bdq_pkg.sv
src/bounded_deque_with_search.sv
bench/tb.sv
